// File: rtl/plane_dip_and_dip_direction_defines.svh
// ----------------------------------------------------------------------------
// plane_dip_and_dip_direction_defines
// Assertion macros shared by the plane dip blocks.
// ----------------------------------------------------------------------------
// Each expects clk and arst_n in scope.
`ifndef PLANE_DIP_AND_DIP_DIRECTION_DEFINES_SVH
`define PLANE_DIP_AND_DIP_DIRECTION_DEFINES_SVH

// cond must never hold at a clock edge out of reset
`define PDD_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// ante at an edge requires cons at the same edge
`define PDD_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/pdd_pkg.sv
// ----------------------------------------------------------------------------
// pdd_pkg
// Shared types and constants for the plane dip / dip direction block.
// ----------------------------------------------------------------------------
package pdd_pkg;

	localparam int NORM_BITS    = 30;
	localparam int CORDIC_STEPS = 30;
	localparam int ANGLE_BITS   = 31;

	// atan(2^-i) as binary angle, 2^32 units per turn
	localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
		30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
		30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
		30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
		30'd20, 30'd10, 30'd5, 30'd3, 30'd1
	};

	// sign class of each normal component
	typedef struct packed {
		logic x_neg;
		logic x_zero;
		logic y_neg;
		logic y_zero;
		logic z_neg;
		logic z_zero;
	} sgn_t;

endpackage

// File: rtl/pdd_front.sv
// ----------------------------------------------------------------------------
// pdd_front
// Edge vectors, cross product and sign classification of the plane normal.
// ----------------------------------------------------------------------------
module pdd_front import pdd_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  logic signed [COORD_WIDTH-1:0] pts [9],
	output logic                          out_valid,
	output logic [2*COORD_WIDTH:0]        mag [3],
	output sgn_t                          sg
);
	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;
	localparam int MW = 2 * COORD_WIDTH + 1;

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [COORD_WIDTH-1:0] p_s1 [9];
	logic signed [DW-1:0] d_s2 [6];
	logic signed [PW-1:0] m_s3 [6];
	logic signed [PW-1:0] c_s4 [3];
	logic [PW-1:0] magf [3];
	logic [2:0] neg, zer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1 <= pts;
			// u = p2 - p1, v = p3 - p1
			for (int i = 0; i < 3; i++) begin
				d_s2[i]   <= DW'(p_s1[3+i]) - DW'(p_s1[i]);
				d_s2[3+i] <= DW'(p_s1[6+i]) - DW'(p_s1[i]);
			end
			m_s3[0] <= PW'(d_s2[1]) * PW'(d_s2[5]);
			m_s3[1] <= PW'(d_s2[2]) * PW'(d_s2[4]);
			m_s3[2] <= PW'(d_s2[2]) * PW'(d_s2[3]);
			m_s3[3] <= PW'(d_s2[0]) * PW'(d_s2[5]);
			m_s3[4] <= PW'(d_s2[0]) * PW'(d_s2[4]);
			m_s3[5] <= PW'(d_s2[1]) * PW'(d_s2[3]);
			c_s4[0] <= m_s3[0] - m_s3[1];
			c_s4[1] <= m_s3[2] - m_s3[3];
			c_s4[2] <= m_s3[4] - m_s3[5];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg[i]  = c_s4[i][PW-1];
			zer[i]  = (c_s4[i] == '0);
			magf[i] = neg[i] ? PW'(-c_s4[i]) : PW'(c_s4[i]);
			mag[i]  = magf[i][MW-1:0];
		end
	end

	assign sg = '{x_neg: neg[0], x_zero: zer[0], y_neg: neg[1], y_zero: zer[1],
		z_neg: neg[2], z_zero: zer[2]};
	assign out_valid = v_s4;

endmodule

// File: rtl/pdd_queue.sv
// ----------------------------------------------------------------------------
// pdd_queue
// Small register queue between the classifier and the angle pipeline.
// ----------------------------------------------------------------------------
`include "plane_dip_and_dip_direction_defines.svh"

module pdd_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         full,
	output logic         empty
);
	localparam int DEPTH = 4;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + AW'(1);
			if (pop)
				rd_q <= rd_q + AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	`PDD_ASSERT_NEVER(a_push_full, push && full, "item pushed into full queue")
	`PDD_ASSERT_NEVER(a_pop_empty, pop && empty, "item popped from empty queue")

endmodule

// File: rtl/pdd_cordic.sv
// ----------------------------------------------------------------------------
// pdd_cordic
// Pipelined CORDIC vectoring, atan(opp/adj) as binary angle in 0..2^30.
// ----------------------------------------------------------------------------
module pdd_cordic import pdd_pkg::*; (
	input  logic                  clk,
	input  logic                  en,
	input  logic [ANGLE_BITS-1:0] opp,
	input  logic [ANGLE_BITS-1:0] adj,
	output logic [ANGLE_BITS-1:0] angle
);
	localparam int XW = ANGLE_BITS + 4;
	localparam int ZW = 33;
	localparam int N  = CORDIC_STEPS;

	logic signed [XW-1:0] x_q [N+1];
	logic signed [XW-1:0] y_q [N+1];
	logic signed [ZW-1:0] z_q [N+1];
	logic az_q [N+1];
	logic oz_q [N+1];

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0]  <= XW'($signed({1'b0, adj}));
			y_q[0]  <= XW'($signed({1'b0, opp}));
			z_q[0]  <= '0;
			az_q[0] <= (adj == '0);
			oz_q[0] <= (opp == '0);
			for (int k = 0; k < N; k++) begin
				az_q[k+1] <= az_q[k];
				oz_q[k+1] <= oz_q[k];
				if (!y_q[k][XW-1] && y_q[k] != '0) begin
					x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
					y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
					z_q[k+1] <= z_q[k] + $signed({3'b000, ATAN_TAB[k]});
				end else begin
					x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
					y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
					z_q[k+1] <= z_q[k] - $signed({3'b000, ATAN_TAB[k]});
				end
			end
		end
	end

	// zero adjacent side wins over zero opposite side
	always_comb begin
		if (az_q[N])
			angle = ANGLE_BITS'(1) << 30;
		else if (oz_q[N] || z_q[N][ZW-1])
			angle = '0;
		else if (z_q[N] > $signed(ZW'(1) << 30))
			angle = ANGLE_BITS'(1) << 30;
		else
			angle = z_q[N][ANGLE_BITS-1:0];
	end

endmodule

// File: rtl/pdd_back.sv
// ----------------------------------------------------------------------------
// pdd_back
// Normalize, magnitude square root, two arctangents, quadrant fixup and
// conversion to degrees/minutes/seconds.
// ----------------------------------------------------------------------------
module pdd_back import pdd_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   take,
	input  logic [2*COORD_WIDTH:0] mag [3],
	input  sgn_t                   sg,
	input  logic                   pop,
	output logic                   empty,
	output logic [6:0]             dip_degrees,
	output logic [5:0]             dip_minutes,
	output logic [5:0]             dip_seconds,
	output logic [8:0]             direction_degrees,
	output logic [5:0]             direction_minutes,
	output logic [5:0]             direction_seconds,
	output logic                   degenerate
);
	localparam int MW  = 2 * COORD_WIDTH + 1;
	localparam int LW  = $clog2(MW + 1);
	localparam int SQ  = NORM_BITS + 1;
	localparam int SVW = 2 * NORM_BITS + 2;
	localparam int CL  = CORDIC_STEPS + 1;
	localparam int NST = 5 + SQ + CL + 7;
	localparam logic [32:0] HALF = 33'h0_8000_0000;
	localparam logic [32:0] FULL = 33'h1_0000_0000;
	localparam logic [20:0] SEC_MAX = 21'd1295999;

	typedef struct packed {
		logic [14:0] quo;
		logic [5:0]  rem;
	} qr_t;

	function automatic logic [LW-1:0] bit_len(input logic [MW-1:0] v);
		logic [LW-1:0] n;
		n = '0;
		for (int i = 0; i < MW; i++)
			if (v[i])
				n = LW'(i + 1);
		return n;
	endfunction

	function automatic logic [MW-1:0] mag_or(input logic [MW-1:0] v [3]);
		return v[0] | v[1] | v[2];
	endfunction

	// reciprocal estimate of x/60, high by at most one
	function automatic logic [14:0] div60_est(input logic [20:0] x);
		return 15'(({16'd0, x} * 37'd34953) >> 21);
	endfunction

	function automatic qr_t div60_fix(input logic [20:0] x, input logic [14:0] qh);
		logic [20:0] p;
		qr_t r;
		p = 21'({6'd0, qh} * 21'd60);
		if (x < p) begin
			r.quo = qh - 15'd1;
			r.rem = 6'(x + 21'd60 - p);
		end else begin
			r.quo = qh;
			r.rem = 6'(x - p);
		end
		return r;
	endfunction

	logic [NST-1:0] v_q;
	logic be;

	logic [MW-1:0] m_s1 [3];
	logic [MW-1:0] m_s2 [3];
	sgn_t sg_s1, sg_s2, sg_s3, sg_s4;
	logic [LW-1:0] len_s2;
	logic [LW-1:0] sh;
	logic [NORM_BITS-1:0] n_s3 [3];
	logic [NORM_BITS-1:0] n_s4 [3];
	logic [2*NORM_BITS-1:0] sqx_s4, sqy_s4;

	logic [SVW-1:0] sqv_q [SQ+1];
	logic [SVW-1:0] sqr_q [SQ+1];
	logic [NORM_BITS-1:0] snx_q [SQ+1];
	logic [NORM_BITS-1:0] sny_q [SQ+1];
	logic [NORM_BITS-1:0] snz_q [SQ+1];
	sgn_t ssg_q [SQ+1];
	sgn_t csg_q [1:CL];

	logic [ANGLE_BITS-1:0] a_dip, a_t;
	logic [32:0] t_ang, dd;
	logic x_pos, z_pos;

	logic [32:0] ang_a [2];
	logic [53:0] prod_b [2];
	logic [20:0] st_c [2];
	logic [20:0] st_d [2];
	logic [14:0] qh_d [2];
	logic [14:0] mt_e [2];
	logic [5:0]  sec_e [2];
	logic [14:0] mt_f [2];
	logic [14:0] qh_f [2];
	logic [5:0]  sec_f [2];
	logic [8:0]  deg_g [2];
	logic [5:0]  min_g [2];
	logic [5:0]  sec_g [2];
	logic dg_a, dg_b, dg_c, dg_d, dg_e, dg_f, dg_g;
	qr_t fx_e [2];
	qr_t fx_g [2];

	assign empty = !v_q[NST-1];
	assign be    = empty || pop;
	assign take  = be && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else if (be)
			v_q <= {v_q[NST-2:0], take};
	end

	assign sh = (len_s2 > LW'(NORM_BITS)) ? len_s2 - LW'(NORM_BITS) : '0;

	pdd_cordic u_dip (
		.clk   (clk),
		.en    (be),
		.opp   (sqr_q[SQ][ANGLE_BITS-1:0]),
		.adj   ({1'b0, snz_q[SQ]}),
		.angle (a_dip)
	);

	pdd_cordic u_dir (
		.clk   (clk),
		.en    (be),
		.opp   ({1'b0, snx_q[SQ]}),
		.adj   ({1'b0, sny_q[SQ]}),
		.angle (a_t)
	);

	// quadrant placement of the dip direction
	always_comb begin
		t_ang = csg_q[CL].y_neg ? HALF - 33'(a_t) : 33'(a_t);
		x_pos = !csg_q[CL].x_neg && !csg_q[CL].x_zero;
		z_pos = !csg_q[CL].z_neg && !csg_q[CL].z_zero;
		if (!csg_q[CL].x_neg && z_pos)
			dd = t_ang;
		else if (x_pos && !z_pos)
			dd = t_ang + HALF;
		else if (csg_q[CL].x_neg && !csg_q[CL].z_neg)
			dd = FULL - t_ang;
		else if (!x_pos && csg_q[CL].z_neg)
			dd = HALF - t_ang;
		else
			dd = '0;
	end

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			fx_e[l] = div60_fix(st_d[l], qh_d[l]);
			fx_g[l] = div60_fix(21'(mt_f[l]), qh_f[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			m_s1   <= mag;
			sg_s1  <= sg;
			len_s2 <= bit_len(mag_or(m_s1));
			m_s2   <= m_s1;
			sg_s2  <= sg_s1;
			for (int i = 0; i < 3; i++)
				n_s3[i] <= NORM_BITS'(m_s2[i] >> sh);
			sg_s3  <= sg_s2;
			sqx_s4 <= n_s3[0] * n_s3[0];
			sqy_s4 <= n_s3[1] * n_s3[1];
			n_s4   <= n_s3;
			sg_s4  <= sg_s3;

			sqv_q[0] <= SVW'(sqx_s4) + SVW'(sqy_s4);
			sqr_q[0] <= '0;
			snx_q[0] <= n_s4[0];
			sny_q[0] <= n_s4[1];
			snz_q[0] <= n_s4[2];
			ssg_q[0] <= sg_s4;
			// one result bit per stage, test bit 4^(SQ-1-k)
			for (int k = 0; k < SQ; k++) begin
				if (sqv_q[k] >= sqr_q[k] + (SVW'(1) << (2 * (SQ - 1 - k)))) begin
					sqv_q[k+1] <= sqv_q[k] - (sqr_q[k] + (SVW'(1) << (2 * (SQ - 1 - k))));
					sqr_q[k+1] <= (sqr_q[k] >> 1) + (SVW'(1) << (2 * (SQ - 1 - k)));
				end else begin
					sqv_q[k+1] <= sqv_q[k];
					sqr_q[k+1] <= sqr_q[k] >> 1;
				end
				snx_q[k+1] <= snx_q[k];
				sny_q[k+1] <= sny_q[k];
				snz_q[k+1] <= snz_q[k];
				ssg_q[k+1] <= ssg_q[k];
			end

			csg_q[1] <= ssg_q[SQ];
			for (int k = 1; k < CL; k++)
				csg_q[k+1] <= csg_q[k];

			ang_a[0] <= 33'(a_dip);
			ang_a[1] <= dd;
			dg_a     <= csg_q[CL].x_zero && csg_q[CL].y_zero && csg_q[CL].z_zero;
			dg_b     <= dg_a;
			dg_c     <= dg_b;
			dg_d     <= dg_c;
			dg_e     <= dg_d;
			dg_f     <= dg_e;
			dg_g     <= dg_f;
			for (int l = 0; l < 2; l++) begin
				prod_b[l] <= {21'd0, ang_a[l]} * 54'd1296000;
				st_c[l]   <= (prod_b[l][53:32] > {1'b0, SEC_MAX}) ? SEC_MAX
					: prod_b[l][52:32];
				st_d[l]   <= st_c[l];
				qh_d[l]   <= div60_est(st_c[l]);
				mt_e[l]   <= fx_e[l].quo;
				sec_e[l]  <= fx_e[l].rem;
				mt_f[l]   <= mt_e[l];
				qh_f[l]   <= div60_est(21'(mt_e[l]));
				sec_f[l]  <= sec_e[l];
				deg_g[l]  <= dg_f ? '0 : fx_g[l].quo[8:0];
				min_g[l]  <= dg_f ? '0 : fx_g[l].rem;
				sec_g[l]  <= dg_f ? '0 : sec_f[l];
			end
		end
	end

	assign dip_degrees       = deg_g[0][6:0];
	assign dip_minutes       = min_g[0];
	assign dip_seconds       = sec_g[0];
	assign direction_degrees = deg_g[1];
	assign direction_minutes = min_g[1];
	assign direction_seconds = sec_g[1];
	assign degenerate        = dg_g;

endmodule

// File: rtl/plane_dip_and_dip_direction.sv
// ----------------------------------------------------------------------------
// plane_dip_and_dip_direction
// Dip and dip direction, in degrees/minutes/seconds, of the plane through
// three points.
// ----------------------------------------------------------------------------
// channel   direction  handshake         payload
// input     in         push / full       p1_x .. p3_z
// result    out        empty / pop       dip_*, direction_*, degenerate
//
// One item per cycle sustained while the result side pops without gaps. The
// front (cross product) feeds the angle pipeline, whose length is set by the
// 31-step square root and the 30-step arctangent pipelines, via the middle queue.
// A held result stalls only the angle pipeline; the front keeps taking items
// until the four-entry middle queue fills. Reset clears valids and pointers.
// ----------------------------------------------------------------------------
`include "plane_dip_and_dip_direction_defines.svh"

module plane_dip_and_dip_direction import pdd_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [COORD_WIDTH-1:0] p1_x,
	input  logic signed [COORD_WIDTH-1:0] p1_y,
	input  logic signed [COORD_WIDTH-1:0] p1_z,
	input  logic signed [COORD_WIDTH-1:0] p2_x,
	input  logic signed [COORD_WIDTH-1:0] p2_y,
	input  logic signed [COORD_WIDTH-1:0] p2_z,
	input  logic signed [COORD_WIDTH-1:0] p3_x,
	input  logic signed [COORD_WIDTH-1:0] p3_y,
	input  logic signed [COORD_WIDTH-1:0] p3_z,
	output logic                          empty,
	input  logic                          pop,
	output logic [6:0]                    dip_degrees,
	output logic [5:0]                    dip_minutes,
	output logic [5:0]                    dip_seconds,
	output logic [8:0]                    direction_degrees,
	output logic [5:0]                    direction_minutes,
	output logic [5:0]                    direction_seconds,
	output logic                          degenerate
);
	localparam int MW = 2 * COORD_WIDTH + 1;
	localparam int QW = 3 * MW + $bits(sgn_t);

	logic signed [COORD_WIDTH-1:0] pts [9];
	logic f_adv, f_valid;
	logic [MW-1:0] f_mag [3];
	sgn_t f_sg;
	logic q_push, q_full, q_empty, q_pop;
	logic [QW-1:0] q_din, q_dout;
	logic [MW-1:0] b_mag [3];
	sgn_t b_sg;

	assign pts = '{p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z};

	// front stalls only while its last stage waits on a full queue
	assign f_adv  = !(f_valid && q_full);
	assign full   = !f_adv;
	assign q_push = f_valid && !q_full;
	assign q_din  = {f_mag[0], f_mag[1], f_mag[2], f_sg};
	assign {b_mag[0], b_mag[1], b_mag[2], b_sg} = q_dout;

	pdd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (f_adv),
		.in_valid  (push && !full),
		.pts       (pts),
		.out_valid (f_valid),
		.mag       (f_mag),
		.sg        (f_sg)
	);

	pdd_queue #(.W(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.full   (q_full),
		.empty  (q_empty)
	);

	pdd_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (!q_empty),
		.take              (q_pop),
		.mag               (b_mag),
		.sg                (b_sg),
		.pop               (pop),
		.empty             (empty),
		.dip_degrees       (dip_degrees),
		.dip_minutes       (dip_minutes),
		.dip_seconds       (dip_seconds),
		.direction_degrees (direction_degrees),
		.direction_minutes (direction_minutes),
		.direction_seconds (direction_seconds),
		.degenerate        (degenerate)
	);

	`PDD_ASSERT_IMPLIES(a_degen_zero, !empty && degenerate,
		dip_degrees == 7'd0 && dip_minutes == 6'd0 && dip_seconds == 6'd0 &&
		direction_degrees == 9'd0 && direction_minutes == 6'd0 &&
		direction_seconds == 6'd0, "degenerate item with nonzero angles")
	`PDD_ASSERT_IMPLIES(a_angle_range, !empty,
		dip_degrees <= 7'd90 && direction_degrees <= 9'd359 &&
		dip_minutes <= 6'd59 && direction_minutes <= 6'd59, "angle out of range")

endmodule

// File: test/plane_dip_and_dip_direction_tb.sv
// ----------------------------------------------------------------------------
// plane_dip_and_dip_direction_tb
// Drives point triples into the plane dip block with random gaps on both
// sides, predicts dip and dip direction in fixed point, and checks every
// result in order.
// ----------------------------------------------------------------------------
module plane_dip_and_dip_direction_tb;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 200;

	typedef logic [8:0][31:0] points_t;

	typedef struct packed {
		logic [8:0] deg;
		logic [5:0] min;
		logic [5:0] sec;
	} dms_t;

	typedef struct packed {
		logic [6:0] dip_deg;
		logic [5:0] dip_min;
		logic [5:0] dip_sec;
		logic [8:0] dir_deg;
		logic [5:0] dir_min;
		logic [5:0] dir_sec;
		logic       degen;
	} angles_t;

	// atan(2^-i), 2^32 units per turn
	localparam longint ARCTAN_STEP [30] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3, 1
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	logic signed [31:0] p1_x = '0, p1_y = '0, p1_z = '0;
	logic signed [31:0] p2_x = '0, p2_y = '0, p2_z = '0;
	logic signed [31:0] p3_x = '0, p3_y = '0, p3_z = '0;
	logic [6:0] dip_degrees;
	logic [5:0] dip_minutes, dip_seconds;
	logic [8:0] direction_degrees;
	logic [5:0] direction_minutes, direction_seconds;
	logic degenerate;

	points_t pending_points [$];
	angles_t expected_angles [$];
	points_t on_port;
	int errors = 0;
	int idle_cycles = 0;
	int push_wait = 0;
	int pop_wait = 0;
	bit steady_in = 1'b0;
	bit steady_out = 1'b0;

	plane_dip_and_dip_direction dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
		.p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
		.p3_x(p3_x), .p3_y(p3_y), .p3_z(p3_z),
		.empty(empty), .pop(pop),
		.dip_degrees(dip_degrees), .dip_minutes(dip_minutes), .dip_seconds(dip_seconds),
		.direction_degrees(direction_degrees), .direction_minutes(direction_minutes),
		.direction_seconds(direction_seconds), .degenerate(degenerate)
	);

	always #10 clk = ~clk;

	function automatic logic signed [127:0] wide(longint v);
		logic signed [127:0] w;
		w = 128'(v);
		return w;
	endfunction

	function automatic int bit_length(logic [127:0] v);
		for (int i = 127; i >= 0; i--)
			if (v[i]) return i + 1;
		return 0;
	endfunction

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// vectoring arctangent of opp/adj, quarter turn = 2^30
	function automatic longint unsigned arctan(longint unsigned opp, longint unsigned adj);
		longint x, y, z, dx, dy;
		if (adj == 0) return 64'd1 << 30;
		if (opp == 0) return 0;
		x = adj;
		y = opp;
		z = 0;
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += ARCTAN_STEP[i];
			end else begin
				x -= dx; y += dy; z -= ARCTAN_STEP[i];
			end
		end
		if (z < 0) z = 0;
		if (z > (64'sd1 <<< 30)) z = 64'sd1 <<< 30;
		return z;
	endfunction

	function automatic dms_t to_dms(longint unsigned a);
		longint unsigned s;
		dms_t d;
		s = (a * 64'd1296000) >> 32;
		if (s > 64'd1295999) s = 64'd1295999;
		d.deg = 9'(s / 3600);
		d.min = 6'((s / 60) % 60);
		d.sec = 6'(s % 60);
		return d;
	endfunction

	function automatic angles_t plane_angles(points_t p);
		longint q [9];
		longint ux, uy, uz, vx, vy, vz;
		logic signed [127:0] cx, cy, cz;
		logic [127:0] mx, my, mz;
		int sx, sy, sz, len, sh;
		longint unsigned nx, ny, nz, r, dip, t, dd;
		dms_t a, b;
		angles_t o;
		for (int k = 0; k < 9; k++) q[k] = longint'($signed(p[k]));
		ux = q[3] - q[0]; uy = q[4] - q[1]; uz = q[5] - q[2];
		vx = q[6] - q[0]; vy = q[7] - q[1]; vz = q[8] - q[2];
		cx = wide(uy) * wide(vz) - wide(uz) * wide(vy);
		cy = wide(uz) * wide(vx) - wide(ux) * wide(vz);
		cz = wide(ux) * wide(vy) - wide(uy) * wide(vx);
		sx = cx < 0 ? -1 : (cx == 0 ? 0 : 1);
		sy = cy < 0 ? -1 : (cy == 0 ? 0 : 1);
		sz = cz < 0 ? -1 : (cz == 0 ? 0 : 1);
		o = '0;
		if (sx == 0 && sy == 0 && sz == 0) begin
			o.degen = 1'b1;
			return o;
		end
		mx = cx < 0 ? -cx : cx;
		my = cy < 0 ? -cy : cy;
		mz = cz < 0 ? -cz : cz;
		len = bit_length(mx);
		if (bit_length(my) > len) len = bit_length(my);
		if (bit_length(mz) > len) len = bit_length(mz);
		sh = len > 30 ? len - 30 : 0;
		nx = 64'(mx >> sh);
		ny = 64'(my >> sh);
		nz = 64'(mz >> sh);
		r = int_root(nx * nx + ny * ny);
		dip = arctan(r, nz);
		t = sy >= 0 ? arctan(nx, ny) : (64'd1 << 31) - arctan(nx, ny);
		if (sx >= 0 && sz > 0) dd = t;
		else if (sx > 0 && sz <= 0) dd = t + (64'd1 << 31);
		else if (sx < 0 && sz >= 0) dd = (64'd1 << 32) - t;
		else if (sx <= 0 && sz < 0) dd = (64'd1 << 31) - t;
		else dd = 0;
		a = to_dms(dip);
		b = to_dms(dd);
		o.dip_deg = a.deg[6:0];
		o.dip_min = a.min;
		o.dip_sec = a.sec;
		o.dir_deg = b.deg;
		o.dir_min = b.min;
		o.dir_sec = b.sec;
		return o;
	endfunction

	task automatic add_points(longint a, longint b, longint c, longint d, longint e,
			longint f, longint g, longint h, longint i);
		points_t p;
		p[0] = 32'(a); p[1] = 32'(b); p[2] = 32'(c);
		p[3] = 32'(d); p[4] = 32'(e); p[5] = 32'(f);
		p[6] = 32'(g); p[7] = 32'(h); p[8] = 32'(i);
		pending_points.push_back(p);
	endtask

	// p1 anywhere, p2 = p1 + u, p3 = p1 + v
	task automatic add_edges(longint ox, longint oy, longint oz, longint ux, longint uy,
			longint uz, longint vx, longint vy, longint vz);
		add_points(ox, oy, oz, ox + ux, oy + uy, oz + uz, ox + vx, oy + vy, oz + vz);
	endtask

	function automatic longint small_coord(int span);
		return longint'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic longint any_coord();
		return longint'($signed($urandom()));
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	// input side
	always @(posedge clk or negedge arst_n) begin
		logic next_push;
		points_t p;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			next_push = push;
			if (push && !full) begin
				expected_angles.push_back(plane_angles(on_port));
				next_push = 1'b0;
				if ($urandom_range(0, 39) == 0) steady_in = ~steady_in;
			end
			if (!next_push && pending_points.size() > 0) begin
				if (push_wait > 0)
					push_wait--;
				else begin
					p = pending_points.pop_front();
					on_port = p;
					{p3_z, p3_y, p3_x, p2_z, p2_y, p2_x, p1_z, p1_y, p1_x} <= p;
					next_push = 1'b1;
					push_wait = steady_in ? 0 : int'($urandom_range(0, 9));
				end
			end
			push <= next_push;
		end
	end

	// result side
	always @(posedge clk or negedge arst_n) begin
		logic next_pop;
		angles_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			next_pop = pop;
			if (pop && !empty) begin
				if (expected_angles.size() == 0) begin
					$display("result with no item outstanding");
					errors++;
				end else begin
					want = expected_angles.pop_front();
					if (dip_degrees != want.dip_deg)
						report("dip_degrees", int'(dip_degrees), int'(want.dip_deg));
					if (dip_minutes != want.dip_min)
						report("dip_minutes", int'(dip_minutes), int'(want.dip_min));
					if (dip_seconds != want.dip_sec)
						report("dip_seconds", int'(dip_seconds), int'(want.dip_sec));
					if (direction_degrees != want.dir_deg)
						report("direction_degrees", int'(direction_degrees),
							int'(want.dir_deg));
					if (direction_minutes != want.dir_min)
						report("direction_minutes", int'(direction_minutes),
							int'(want.dir_min));
					if (direction_seconds != want.dir_sec)
						report("direction_seconds", int'(direction_seconds),
							int'(want.dir_sec));
					if (degenerate != want.degen)
						report("degenerate", int'(degenerate), int'(want.degen));
				end
				next_pop = 1'b0;
				pop_wait = steady_out ? 0 : int'($urandom_range(0, 9));
				if ($urandom_range(0, 39) == 0) steady_out = ~steady_out;
			end
			if (!next_pop) begin
				if (pop_wait > 0) pop_wait--;
				else next_pop = 1'b1;
			end
			pop <= next_pop;
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		longint mx, mn, ox, oy, oz, k;
		mx = 64'sd2147483647;
		mn = -64'sd2147483648;
		// degenerate: coincident and collinear points
		add_points(0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_edges(5, 6, 7, 1, 2, 3, 2, 4, 6);
		add_points(mn, mn, mn, mx, mx, mx, 0, 0, 0);
		// horizontal planes, both normal orientations
		add_edges(0, 0, 0, 1, 0, 0, 0, 1, 0);
		add_edges(0, 0, 0, 0, 1, 0, 1, 0, 0);
		// normal along y only: nx and nz both zero
		add_edges(0, 0, 0, 1, 0, 0, 0, 0, 1);
		add_edges(0, 0, 0, 0, 0, 1, 1, 0, 0);
		// normal along x only
		add_edges(0, 0, 0, 0, 1, 0, 0, 0, 1);
		add_edges(0, 0, 0, 0, 0, 1, 0, 1, 0);
		// each sign combination of nx and nz
		add_edges(0, 0, 0, 1, 0, 1, 0, 1, 0);
		add_edges(0, 0, 0, 1, 0, -1, 0, 1, 0);
		add_edges(0, 0, 0, -1, 0, 1, 0, 1, 0);
		add_edges(0, 0, 0, -1, 0, -1, 0, 1, 0);
		add_edges(0, 0, 0, 1, 0, 1, 0, -1, 0);
		add_edges(0, 0, 0, -1, 0, -1, 0, -1, 0);
		// tiny ny next to huge nz: shifts to zero but keeps its sign
		add_points(mn, 0, 0, mx, 0, 0, mn, mx, 1);
		add_points(mn, 0, 0, mx, 0, 0, mn, mx, -1);
		// coordinate extremes
		add_points(mx, mx, mx, mn, mn, mn, mx, mn, mx);
		add_points(mn, mx, mn, mx, mn, mx, mn, mn, mx);
		add_points(mx, mn, mn, mn, mx, mn, mn, mn, mx);
		add_points(-1, -1, -1, mx, 0, mn, 0, mx, mn);
		// dip direction at a quarter turn and just above zero
		add_edges(0, 0, 0, -1, 0, 1, 0, 100000, 0);
		add_edges(0, 0, 0, 1, 0, -1000000, -1000000, 1, 0);

		for (int n = 0; n < 550; n++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: add_points(any_coord(), any_coord(), any_coord(), any_coord(),
					any_coord(), any_coord(), any_coord(), any_coord(), any_coord());
				3, 4: begin
					ox = small_coord(100000); oy = small_coord(100000); oz = small_coord(100000);
					add_edges(ox, oy, oz, small_coord(1000), small_coord(1000), small_coord(1000),
						small_coord(1000), small_coord(1000), small_coord(1000));
				end
				5: begin
					// collinear
					ox = small_coord(1000000); oy = small_coord(1000000); oz = small_coord(1000000);
					k = small_coord(20);
					mx = small_coord(3000); mn = small_coord(3000);
					add_edges(ox, oy, oz, mx, mn, k, mx * 3, mn * 3, k * 3);
					mx = 64'sd2147483647; mn = -64'sd2147483648;
				end
				6: begin
					// level plane
					oz = any_coord();
					add_points(small_coord(50000), small_coord(50000), oz,
						small_coord(50000), small_coord(50000), oz,
						small_coord(50000), small_coord(50000), oz);
				end
				7: begin
					// vertical plane
					ox = small_coord(50000); oy = small_coord(50000);
					add_points(ox, oy, small_coord(50000), ox + 2 * oy, oy - 3 * ox,
						small_coord(50000), ox, oy, small_coord(50000));
				end
				8: add_edges(small_coord(5), small_coord(5), small_coord(5),
					small_coord(2), small_coord(2), small_coord(2),
					small_coord(2), small_coord(2), small_coord(2));
				default: begin
					// steep plane: long edge u nearly level, long edge v nearly vertical
					ox = any_coord() >>> 2;
					add_edges(ox, 0, 0, any_coord() >>> 2, any_coord() >>> 2, small_coord(3),
						small_coord(3), small_coord(3), any_coord() >>> 2);
				end
			endcase
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk);
		while (pending_points.size() > 0 || push || expected_angles.size() > 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/pdd_pkg.sv
rtl/pdd_front.sv
rtl/pdd_queue.sv
rtl/pdd_cordic.sv
rtl/pdd_back.sv
rtl/plane_dip_and_dip_direction.sv
test/plane_dip_and_dip_direction_tb.sv
